/* rtl/dcit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcit_pkg
// Shared types and constants of the interval timer: commands, register
// selectors, control bit positions and the word formats of both channels.
// ----------------------------------------------------------------------------
package dcit_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int CR1_WIDTH   = 5;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [DATA_WIDTH-1:0]  data_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CR1  = 3'd0,
    REG_DIER = 3'd1,
    REG_SR   = 3'd2,
    REG_EGR  = 3'd3,
    REG_CNT  = 3'd4,
    REG_ARR  = 3'd5
  } reg_sel_t;

  // CR1 bit positions
  localparam int CR1_CEN  = 0;
  localparam int CR1_UDIS = 1;
  localparam int CR1_URS  = 2;
  localparam int CR1_OPM  = 3;
  localparam int CR1_DIR  = 4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_sel;
    data_t      wdata;
  } item_t;

  typedef struct packed {
    data_t rdata;
    logic  irq;
    logic  update_event;
  } result_t;

endpackage

/* rtl/dcit_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcit channel interfaces
// Valid/ready channels for bus items, result words and the prescaler write.
// ----------------------------------------------------------------------------
interface dcit_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [2:0]          reg_sel;
  dcit_pkg::data_t     wdata;

  modport source (output valid, output cmd, output reg_sel, output wdata, input ready);
  modport sink   (input valid, input cmd, input reg_sel, input wdata, output ready);
endinterface

interface dcit_out_if;
  logic                valid;
  logic                ready;
  dcit_pkg::data_t     rdata;
  logic                irq;
  logic                update_event;

  modport source (output valid, output rdata, output irq, output update_event, input ready);
  modport sink   (input valid, input rdata, input irq, input update_event, output ready);
endinterface

interface dcit_cfg_if;
  logic                valid;
  logic                ready;
  dcit_pkg::data_t     prescale;

  modport source (output valid, output prescale, input ready);
  modport sink   (input valid, input prescale, output ready);
endinterface

/* rtl/down_counting_interval_timer.sv */
`timescale 1ns / 1ps
// Accepted words are held in the input register, results in the result register once free.
// Throughput: one word per cycle; a waiting result lets one more word in, then stalls in_ch.
// Prescaler writes are taken at once on every cycle.
// Reset (rst_n low, synchronous) clears all timer registers, the prescaler and
// both stage valid flags.
// ----------------------------------------------------------------------------
// down_counting_interval_timer
// Prescaled auto-reload up/down timer with one-pulse mode, driven by bus words.
// ----------------------------------------------------------------------------
module down_counting_interval_timer (
  input logic        clk,
  input logic        rst_n,
  dcit_in_if.sink    in_ch,
  dcit_out_if.source out_ch,
  dcit_cfg_if.sink   cfg_ch
);
  import dcit_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t result;
  result_t out_result;
  logic    advance;
  logic    fire;

  assign in_item.cmd     = in_ch.cmd;
  assign in_item.reg_sel = in_ch.reg_sel;
  assign in_item.wdata   = in_ch.wdata;

  assign cfg_ch.ready = 1'b1;

  dcit_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  dcit_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_ch.valid),
    .cfg_prescale (cfg_ch.prescale),
    .fire         (fire),
    .item         (item),
    .result       (result)
  );

  dcit_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.rdata        = out_result.rdata;
  assign out_ch.irq          = out_result.irq;
  assign out_ch.update_event = out_result.update_event;

endmodule

/* rtl/dcit_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcit_in_stage
// Input register: holds one bus word until the core consumes it.
// ----------------------------------------------------------------------------
module dcit_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dcit_pkg::item_t in_item,
  input  logic            advance,
  output logic            fire,
  output dcit_pkg::item_t item
);
  import dcit_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign fire     = valid_r && advance;
  assign in_ready = !valid_r || advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/dcit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcit_core
// Timer registers and the single-pass update for one bus word: tick,
// register write or register read, with the result word formed alongside.
// ----------------------------------------------------------------------------
module dcit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  dcit_pkg::data_t   cfg_prescale,
  input  logic              fire,
  input  dcit_pkg::item_t   item,
  output dcit_pkg::result_t result
);
  import dcit_pkg::*;

  data_t                psc_r,   psc_nxt;
  data_t                pcnt_r,  pcnt_nxt;
  count_t               cnt_r,   cnt_nxt;
  count_t               arr_r,   arr_nxt;
  logic [CR1_WIDTH-1:0] cr1_r,   cr1_nxt;
  logic                 ier_r,   ier_nxt;
  logic                 uif_r,   uif_nxt;
  logic                 ev;
  logic                 wrapped;
  count_t               step_cnt;
  data_t                rd;

  // counter step at a prescaled tick
  always_comb begin
    if (cr1_r[CR1_DIR]) begin
      wrapped  = (cnt_r == '0);
      step_cnt = wrapped ? arr_r : cnt_r - COUNT_WIDTH'(1);
    end else begin
      wrapped  = (cnt_r >= arr_r);
      step_cnt = wrapped ? '0 : cnt_r + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    pcnt_nxt = pcnt_r;
    cnt_nxt  = cnt_r;
    arr_nxt  = arr_r;
    cr1_nxt  = cr1_r;
    ier_nxt  = ier_r;
    uif_nxt  = uif_r;
    ev       = 1'b0;
    rd       = '0;
    case (item.cmd)
      CMD_TICK: begin
        if (cr1_r[CR1_CEN]) begin
          if (pcnt_r >= psc_r) begin
            pcnt_nxt = '0;
            cnt_nxt  = step_cnt;
            if (wrapped && !cr1_r[CR1_UDIS]) begin
              ev      = 1'b1;
              uif_nxt = 1'b1;
              if (cr1_r[CR1_OPM]) begin
                cr1_nxt[CR1_CEN] = 1'b0;
              end
            end
          end else begin
            pcnt_nxt = pcnt_r + 16'd1;
          end
        end
      end
      CMD_WRITE: begin
        unique case (item.reg_sel)
          REG_CR1:  cr1_nxt = item.wdata[CR1_WIDTH-1:0];
          REG_DIER: ier_nxt = item.wdata[0];
          REG_SR:   uif_nxt = uif_r & item.wdata[0];
          REG_EGR: begin
            // software update: reload and restart the prescaler
            if (item.wdata[0]) begin
              cnt_nxt  = cr1_r[CR1_DIR] ? arr_r : '0;
              pcnt_nxt = '0;
              if (!cr1_r[CR1_UDIS]) begin
                ev = 1'b1;
                if (!cr1_r[CR1_URS]) begin
                  uif_nxt = 1'b1;
                end
              end
            end
          end
          REG_CNT:  cnt_nxt = COUNT_WIDTH'(item.wdata);
          REG_ARR:  arr_nxt = COUNT_WIDTH'(item.wdata);
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (item.reg_sel)
          REG_CR1:  rd = DATA_WIDTH'(cr1_r);
          REG_DIER: rd = DATA_WIDTH'(ier_r);
          REG_SR:   rd = DATA_WIDTH'(uif_r);
          REG_CNT:  rd = DATA_WIDTH'(cnt_r);
          REG_ARR:  rd = DATA_WIDTH'(arr_r);
          default:  rd = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign psc_nxt = cfg_valid ? cfg_prescale : psc_r;

  assign result.rdata        = rd;
  assign result.irq          = uif_nxt & ier_nxt;
  assign result.update_event = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_r  <= '0;
      pcnt_r <= '0;
      cnt_r  <= '0;
      arr_r  <= '0;
      cr1_r  <= '0;
      ier_r  <= 1'b0;
      uif_r  <= 1'b0;
    end else begin
      psc_r <= psc_nxt;
      if (fire) begin
        pcnt_r <= pcnt_nxt;
        cnt_r  <= cnt_nxt;
        arr_r  <= arr_nxt;
        cr1_r  <= cr1_nxt;
        ier_r  <= ier_nxt;
        uif_r  <= uif_nxt;
      end
    end
  end

  a_tick_event_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_TICK && ev |=> uif_r)
    else $error("tick update did not set the flag");

  a_one_pulse_stops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_TICK && ev && cr1_r[CR1_OPM] |=> !cr1_r[CR1_CEN])
    else $error("one-pulse mode did not clear enable");

  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_TICK && !cr1_r[CR1_CEN] |=> $stable(cnt_r) && $stable(pcnt_r))
    else $error("disabled timer moved");

  a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.rdata != '0 |-> item.cmd == CMD_READ)
    else $error("read data on a non-read word");

endmodule

/* rtl/dcit_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcit_out_stage
// Result register: holds a finished word until the sink takes it.
// ----------------------------------------------------------------------------
module dcit_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  dcit_pkg::result_t result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output dcit_pkg::result_t out_result
);
  import dcit_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign advance    = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

endmodule

/* test/down_counting_interval_timer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// down_counting_interval_timer_tb
// Drives bus words (ticks, register writes and reads) into the interval timer
// and checks every result word against a timer model kept in step with the
// accepted words or, on fixed rows, a short table that covers reset values,
// extremes, one-pulse, update-disable and update-source handling. Random
// phases at several prescaler settings follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module down_counting_interval_timer_tb;
  import dcit_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED6 = 3'd6;
  localparam logic [2:0] REG_UNUSED7 = 3'd7;
  localparam int N_DIRECTED = 26;
  localparam int N_PHASES = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    item_t   word;
    logic    fixed;
    result_t res;
  } dir_row_t;

  // Directed words; fixed rows carry the result read straight off the spec.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{CMD_READ,   REG_CR1,     16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_READ,   REG_CNT,     16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_UNUSED, REG_UNUSED7, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_TICK,   REG_CR1,     16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_ARR,     16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_DIER,    16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_CR1,     16'h0011}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_TICK,   REG_CR1,     16'h0000}, 1'b1, '{16'h0000, 1'b1, 1'b1}},
    '{'{CMD_READ,   REG_CNT,     16'h0000}, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{'{CMD_WRITE,  REG_SR,      16'hFFFF}, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{'{CMD_WRITE,  REG_SR,      16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_UNUSED6, 16'hFFFF}, 1'b0, '0},
    '{'{CMD_READ,   REG_UNUSED7, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_EGR,     16'hFFFE}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_CR1,     16'h001F}, 1'b0, '0},
    '{'{CMD_WRITE,  REG_EGR,     16'h0001}, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{'{CMD_READ,   REG_CNT,     16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{'{CMD_WRITE,  REG_CR1,     16'h000D}, 1'b0, '0},
    '{'{CMD_WRITE,  REG_CNT,     16'hFFFF}, 1'b0, '0},
    '{'{CMD_TICK,   REG_CR1,     16'h0000}, 1'b1, '{16'h0000, 1'b1, 1'b1}},
    '{'{CMD_READ,   REG_CR1,     16'h0000}, 1'b1, '{16'h000C, 1'b1, 1'b0}},
    '{'{CMD_WRITE,  REG_SR,      16'h0000}, 1'b0, '0},
    '{'{CMD_WRITE,  REG_EGR,     16'h0001}, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{'{CMD_WRITE,  REG_CR1,     16'h0001}, 1'b0, '0},
    '{'{CMD_WRITE,  REG_EGR,     16'hFFFF}, 1'b1, '{16'h0000, 1'b1, 1'b1}},
    '{'{CMD_READ,   REG_SR,      16'h0000}, 1'b1, '{16'h0001, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst_n;

  dcit_in_if  in_bus ();
  dcit_out_if out_bus ();
  dcit_cfg_if cfg_bus ();

  down_counting_interval_timer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Timer model state
  count_t                tm_count;
  count_t                tm_reload;
  logic [15:0]           tm_presc_cnt;
  logic [15:0]           tm_prescale;
  logic [CR1_WIDTH-1:0]  tm_ctrl;
  logic                  tm_irq_en;
  logic                  tm_flag;

  result_t pending_results [$];
  int errors = 0;
  int tx_max = 5;
  int rx_max = 5;
  int n_words = 0;
  int n_updates = 0;
  int n_irq = 0;
  int n_results = 0;

  function automatic logic timer_count_step();
    logic wrapped;
    if (tm_ctrl[CR1_DIR]) begin
      wrapped = (tm_count == '0);
      tm_count = wrapped ? tm_reload : tm_count - count_t'(1);
    end else begin
      wrapped = (tm_count >= tm_reload);
      tm_count = wrapped ? '0 : tm_count + count_t'(1);
    end
    if (!wrapped || tm_ctrl[CR1_UDIS])
      return 1'b0;
    tm_flag = 1'b1;
    if (tm_ctrl[CR1_OPM])
      tm_ctrl[CR1_CEN] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic timer_tick();
    if (!tm_ctrl[CR1_CEN])
      return 1'b0;
    if (tm_presc_cnt >= tm_prescale) begin
      tm_presc_cnt = '0;
      return timer_count_step();
    end
    tm_presc_cnt = tm_presc_cnt + 16'd1;
    return 1'b0;
  endfunction

  function automatic logic timer_reg_write(logic [2:0] sel, data_t data);
    case (sel)
      REG_CR1:  tm_ctrl = data[CR1_WIDTH-1:0];
      REG_DIER: tm_irq_en = data[0];
      REG_SR:   tm_flag = tm_flag & data[0];
      REG_EGR: begin
        if (data[0]) begin
          // software update: reload and restart the prescaler
          tm_count = tm_ctrl[CR1_DIR] ? tm_reload : '0;
          tm_presc_cnt = '0;
          if (tm_ctrl[CR1_UDIS])
            return 1'b0;
          if (!tm_ctrl[CR1_URS])
            tm_flag = 1'b1;
          return 1'b1;
        end
      end
      REG_CNT:  tm_count = count_t'(data);
      REG_ARR:  tm_reload = count_t'(data);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic data_t timer_reg_read(logic [2:0] sel);
    case (sel)
      REG_CR1:  return data_t'(tm_ctrl);
      REG_DIER: return data_t'(tm_irq_en);
      REG_SR:   return data_t'(tm_flag);
      REG_CNT:  return data_t'(tm_count);
      REG_ARR:  return data_t'(tm_reload);
      default:  return '0;
    endcase
  endfunction

  function automatic result_t predict_timer_word(item_t w);
    result_t r;
    r = '0;
    case (w.cmd)
      CMD_TICK:  r.update_event = timer_tick();
      CMD_WRITE: r.update_event = timer_reg_write(w.reg_sel, w.wdata);
      CMD_READ:  r.rdata = timer_reg_read(w.reg_sel);
      default: ;
    endcase
    r.irq = tm_flag & tm_irq_en;
    return r;
  endfunction

  function automatic item_t random_bus_word();
    item_t w;
    int pick;
    int reg_pick;
    pick = $urandom_range(0, 99);
    w.wdata = data_t'($urandom);
    w.reg_sel = 3'($urandom_range(0, 7));
    if (pick < 45) begin
      w.cmd = CMD_TICK;
    end else if (pick < 80) begin
      w.cmd = CMD_WRITE;
      reg_pick = $urandom_range(0, 19);
      if (reg_pick < 5) begin
        // mostly keep the timer running so wraps keep coming
        w.reg_sel = REG_CR1;
        w.wdata[CR1_CEN] = ($urandom_range(0, 9) < 8);
        w.wdata[CR1_UDIS] = ($urandom_range(0, 9) < 2);
      end else if (reg_pick < 7) begin
        w.reg_sel = REG_DIER;
      end else if (reg_pick < 10) begin
        w.reg_sel = REG_SR;
      end else if (reg_pick < 13) begin
        w.reg_sel = REG_EGR;
      end else if (reg_pick < 19) begin
        w.reg_sel = (reg_pick < 16) ? REG_CNT : REG_ARR;
        if ($urandom_range(0, 3) != 0)
          w.wdata = data_t'($urandom_range(0, 15));
      end else begin
        w.reg_sel = ($urandom_range(0, 1) != 0) ? REG_UNUSED6 : REG_UNUSED7;
      end
    end else if (pick < 96) begin
      w.cmd = CMD_READ;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR at %0t: result word %0d %s: got %0h, expected %0h",
               $time, idx, what, got, want);
  endtask

  // Present one bus word after a random gap; predict it once accepted.
  task automatic send_bus_word(item_t w, logic fixed, result_t fixed_res);
    int gap;
    result_t r;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.cmd <= w.cmd;
    in_bus.reg_sel <= w.reg_sel;
    in_bus.wdata <= w.wdata;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    r = predict_timer_word(w);
    if (fixed)
      r = fixed_res;
    pending_results.push_back(r);
    n_words++;
    n_updates += int'(r.update_event);
    n_irq += int'(r.irq);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_prescale(data_t value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.prescale <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    tm_prescale = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Result side: random stalls, check each word at the edge it is taken.
  initial begin
    int stall;
    result_t want;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing expected", n_results,
                        32'(out_bus.rdata), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.rdata !== want.rdata)
          report_mismatch("rdata", n_results, 32'(out_bus.rdata), 32'(want.rdata));
        if (out_bus.irq !== want.irq)
          report_mismatch("irq", n_results, 32'(out_bus.irq), 32'(want.irq));
        if (out_bus.update_event !== want.update_event)
          report_mismatch("update_event", n_results, 32'(out_bus.update_event),
                          32'(want.update_event));
      end
      n_results++;
    end
  end

  initial begin
    #5ms;
    $display("Timeout: %0d result words still expected", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    data_t presc_list [N_PHASES];
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_TICK;
    in_bus.reg_sel = REG_CR1;
    in_bus.wdata = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.prescale = '0;
    tm_count = '0;
    tm_reload = '0;
    tm_presc_cnt = '0;
    tm_prescale = '0;
    tm_ctrl = '0;
    tm_irq_en = 1'b0;
    tm_flag = 1'b0;
    presc_list = '{16'h0000, 16'h0001, 16'h0003, 16'hFFFF, 16'h0002, 16'h0000,
                   data_t'($urandom_range(4, 12)), data_t'($urandom_range(0, 65535))};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_bus_word(DIRECTED[i].word, DIRECTED[i].fixed, DIRECTED[i].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_prescale(presc_list[ph]);
      // some phases run one side or the other without gaps
      tx_max = (ph % 3 == 2) ? 0 : 5;
      rx_max = (ph % 4 == 1) ? 0 : 5;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k == WORDS_PER_PHASE / 2)
          drain_results();
        send_bus_word(random_bus_word(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d bus words over %0d prescaler settings plus the reset value",
             n_words, N_PHASES);
    $display("Saw %0d update events and %0d words with irq high; %0d mismatches",
             n_updates, n_irq, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/dcit_pkg.sv
rtl/dcit_ifs.sv
rtl/dcit_in_stage.sv
rtl/dcit_core.sv
rtl/dcit_out_stage.sv
rtl/down_counting_interval_timer.sv
test/down_counting_interval_timer_tb.sv
